/* hdl/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// Bisulfite pileup accumulator package
// Shared types, constants, command and status bundles, and the strand map.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

	// Table and buffer geometry.
	localparam int WINDOW   = 1024;
	localparam int WIN_W    = $clog2(WINDOW);
	localparam int MAX_READ = 512;
	localparam int BUF_W    = $clog2(MAX_READ);
	localparam int LEN_W    = $clog2(MAX_READ + 1);
	localparam int CATS     = 8;
	localparam int CAT_W    = $clog2(CATS);

	// Input item kinds.
	typedef enum logic [1:0] {
		KIND_CLEAR   = 2'd0,
		KIND_BEGIN   = 2'd1,
		KIND_BASE    = 2'd2,
		KIND_READOUT = 2'd3
	} kind_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MIN_Q   = 2'd0;
	localparam logic [1:0] CFG_FILT_Q  = 2'd1;
	localparam logic [1:0] CFG_WIN_BEG = 2'd2;
	localparam logic [1:0] CFG_WIN_END = 2'd3;

	// Controller states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HEAD_RD,
		ST_HEAD_CHK,
		ST_TAIL_RD,
		ST_TAIL_CHK,
		ST_POS_INIT,
		ST_OFF_INIT,
		ST_ACC_RD,
		ST_ACC_CHK,
		ST_ACC_WR,
		ST_DONE,
		ST_RO_RD,
		ST_RO_OUT
	} state_t;

	// One table row holds everything kept for one window position.
	typedef struct packed {
		logic [CATS-1:0][23:0] qsum;
		logic [CATS-1:0][15:0] cnt_rev;
		logic [CATS-1:0][15:0] cnt_fwd;
		logic [31:0]           mapq_sum;
		logic [15:0]           depth;
	} row_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_rst;
		logic clr_wr;
		logic hdr_load;
		logic buf_append;
		logic len_clear;
		logic buf_rd;
		logic ptr_zero;
		logic ptr_inc;
		logic ptr_dec;
		logic ptr_tail;
		logic ptr_first;
		logic first_set;
		logic stop_set;
		logic pos_init;
		logic off_init;
		logic step_inc;
		logic tab_rd;
		logic tab_rd_ro;
		logic tab_wr;
		logic ro_load;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic trim;
		logic ptr_last;
		logic acc_end;
		logic beyond;
		logic in_win;
		logic q_ok;
	} sts_t;

	// Strand-mapped category (zero based); strand three uses the row of strand zero.
	function automatic logic [CAT_W-1:0] category_of(input logic [1:0] strand,
		input logic [1:0] base);
		logic [CAT_W-1:0] c;
		c = '0;
		case (strand)
			2'd1: begin
				case (base)
					2'd0: c = CAT_W'(0);
					2'd1: c = CAT_W'(5);
					2'd2: c = CAT_W'(2);
					default: c = CAT_W'(7);
				endcase
			end
			2'd2: begin
				case (base)
					2'd0: c = CAT_W'(4);
					2'd1: c = CAT_W'(1);
					2'd2: c = CAT_W'(6);
					default: c = CAT_W'(3);
				endcase
			end
			default: begin
				case (base)
					2'd0: c = CAT_W'(0);
					2'd1: c = CAT_W'(1);
					2'd2: c = CAT_W'(2);
					default: c = CAT_W'(3);
				endcase
			end
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* hdl/bpa_ctrl.sv */
// ----------------------------------------------------------------------------
// Bisulfite pileup accumulator controller
// Sequences clearing, read buffering, trimming, accumulation and readout.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [1:0]    in_kind,
	input  wire logic          in_last,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire bpa_pkg::sts_t sts,
	output bpa_pkg::cmd_t      cmd
);

	bpa_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;
	logic            accept;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == bpa_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// State register; reset starts with a sweep that zeroes the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			bpa_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = bpa_pkg::ST_IDLE;
				end
			end
			bpa_pkg::ST_IDLE: begin
				if (accept) begin
					case (bpa_pkg::kind_t'(in_kind))
						bpa_pkg::KIND_CLEAR: begin
							cmd.clr_rst = 1'b1;
							state_d     = bpa_pkg::ST_CLEAR;
						end
						bpa_pkg::KIND_BEGIN: begin
							cmd.hdr_load = 1'b1;
						end
						bpa_pkg::KIND_BASE: begin
							cmd.buf_append = 1'b1;
							if (in_last) begin
								cmd.ptr_zero = 1'b1;
								state_d      = bpa_pkg::ST_HEAD_RD;
							end
						end
						default: begin
							cmd.ro_load = 1'b1;
							state_d     = bpa_pkg::ST_RO_RD;
						end
					endcase
				end
			end
			bpa_pkg::ST_HEAD_RD: begin
				cmd.buf_rd = 1'b1;
				state_d    = bpa_pkg::ST_HEAD_CHK;
			end
			bpa_pkg::ST_HEAD_CHK: begin
				if (sts.trim) begin
					if (sts.ptr_last) begin
						state_d = bpa_pkg::ST_DONE;
					end else begin
						cmd.ptr_inc = 1'b1;
						state_d     = bpa_pkg::ST_HEAD_RD;
					end
				end else begin
					cmd.first_set = 1'b1;
					cmd.ptr_tail  = 1'b1;
					state_d       = bpa_pkg::ST_TAIL_RD;
				end
			end
			bpa_pkg::ST_TAIL_RD: begin
				cmd.buf_rd = 1'b1;
				state_d    = bpa_pkg::ST_TAIL_CHK;
			end
			bpa_pkg::ST_TAIL_CHK: begin
				// The first kept base stops this scan, so it never passes it.
				if (sts.trim) begin
					cmd.ptr_dec = 1'b1;
					state_d     = bpa_pkg::ST_TAIL_RD;
				end else begin
					cmd.stop_set  = 1'b1;
					cmd.ptr_first = 1'b1;
					state_d       = bpa_pkg::ST_POS_INIT;
				end
			end
			bpa_pkg::ST_POS_INIT: begin
				cmd.pos_init = 1'b1;
				state_d      = bpa_pkg::ST_OFF_INIT;
			end
			bpa_pkg::ST_OFF_INIT: begin
				cmd.off_init = 1'b1;
				state_d      = bpa_pkg::ST_ACC_RD;
			end
			bpa_pkg::ST_ACC_RD: begin
				if (sts.acc_end || sts.beyond) begin
					state_d = bpa_pkg::ST_DONE;
				end else begin
					cmd.buf_rd = 1'b1;
					state_d    = bpa_pkg::ST_ACC_CHK;
				end
			end
			bpa_pkg::ST_ACC_CHK: begin
				if (sts.in_win && sts.q_ok) begin
					cmd.tab_rd = 1'b1;
					state_d    = bpa_pkg::ST_ACC_WR;
				end else begin
					cmd.step_inc = 1'b1;
					state_d      = bpa_pkg::ST_ACC_RD;
				end
			end
			bpa_pkg::ST_ACC_WR: begin
				cmd.tab_wr   = 1'b1;
				cmd.step_inc = 1'b1;
				state_d      = bpa_pkg::ST_ACC_RD;
			end
			bpa_pkg::ST_DONE: begin
				cmd.len_clear = 1'b1;
				state_d       = bpa_pkg::ST_IDLE;
			end
			bpa_pkg::ST_RO_RD: begin
				cmd.tab_rd    = 1'b1;
				cmd.tab_rd_ro = 1'b1;
				state_d       = bpa_pkg::ST_RO_OUT;
			end
			bpa_pkg::ST_RO_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = bpa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bpa_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/bpa_datapath.sv */
// ----------------------------------------------------------------------------
// Bisulfite pileup accumulator datapath
// Configuration, read buffer, scan pointers, pileup table and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [31:0]   cfg_wdata,
	input  wire logic [31:0]   read_pos,
	input  wire logic [1:0]    strand,
	input  wire logic          orientation,
	input  wire logic [7:0]    mapq,
	input  wire logic [1:0]    base_code,
	input  wire logic [5:0]    quality,
	input  wire logic [2:0]    category,
	input  wire bpa_pkg::cmd_t cmd,
	output bpa_pkg::sts_t      sts,
	output logic [15:0]        depth,
	output logic [23:0]        category_quality_sum,
	output logic [15:0]        count_forward,
	output logic [15:0]        count_reverse,
	output logic [31:0]        mapq_square_sum
);

	localparam int WIN_W = bpa_pkg::WIN_W;
	localparam int BUF_W = bpa_pkg::BUF_W;
	localparam int LEN_W = bpa_pkg::LEN_W;
	localparam int CAT_W = bpa_pkg::CAT_W;

	logic [5:0]  min_q_q, filt_q_q;
	logic [31:0] win_beg_q, win_end_q;

	logic [31:0] hdr_pos_q;
	logic [1:0]  hdr_strand_q;
	logic        hdr_ori_q;
	logic [15:0] msq_q;

	logic [7:0]       buf_mem [bpa_pkg::MAX_READ];
	logic [7:0]       buf_rd_q;
	logic [LEN_W-1:0] len_q, ptr_q, first_q, stop_q;

	logic [32:0] pos_q;
	logic [33:0] off_q;
	logic [WIN_W-1:0] clr_q;
	logic [32:0] ro_off_q;
	logic [CAT_W-1:0] ro_cat_q;
	logic        ro_in;

	bpa_pkg::row_t tab_mem [bpa_pkg::WINDOW];
	bpa_pkg::row_t tab_rd_q, row_new;
	logic [WIN_W-1:0] tab_rd_addr;

	logic [5:0]       cur_q;
	logic [CAT_W-1:0] cur_cat;
	logic [16:0]      depth_inc, cnt_inc;
	logic [24:0]      qsum_inc;
	logic [32:0]      mapq_inc;
	logic [15:0]      cnt_old;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q_q   <= 6'd0;
			filt_q_q  <= 6'd63;
			win_beg_q <= 32'd0;
			win_end_q <= 32'd1023;
		end else if (cfg_we) begin
			case (cfg_index)
				bpa_pkg::CFG_MIN_Q:   min_q_q   <= cfg_wdata[5:0];
				bpa_pkg::CFG_FILT_Q:  filt_q_q  <= cfg_wdata[5:0];
				bpa_pkg::CFG_WIN_BEG: win_beg_q <= cfg_wdata;
				bpa_pkg::CFG_WIN_END: win_end_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Read header, with the mapq square formed once per read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q    <= '0;
			hdr_strand_q <= '0;
			hdr_ori_q    <= 1'b0;
			msq_q        <= '0;
		end else if (cmd.hdr_load) begin
			hdr_pos_q    <= read_pos;
			hdr_strand_q <= strand;
			hdr_ori_q    <= orientation;
			msq_q        <= 16'(mapq * mapq);
		end
	end

	// Buffered read length; bases past the buffer depth are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.hdr_load || cmd.len_clear) begin
			len_q <= '0;
		end else if (cmd.buf_append && len_q < LEN_W'(bpa_pkg::MAX_READ)) begin
			len_q <= len_q + LEN_W'(1);
		end
	end

	// Read buffer memory with registered read.
	always_ff @(posedge clk) begin
		if (cmd.buf_append && len_q < LEN_W'(bpa_pkg::MAX_READ)) begin
			buf_mem[len_q[BUF_W-1:0]] <= {base_code, quality};
		end
		if (cmd.buf_rd) begin
			buf_rd_q <= buf_mem[ptr_q[BUF_W-1:0]];
		end
	end

	// Scan pointer and trimmed bounds.
	always_ff @(posedge clk) begin
		if (cmd.ptr_zero) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc || cmd.step_inc) begin
			ptr_q <= ptr_q + LEN_W'(1);
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - LEN_W'(1);
		end else if (cmd.ptr_tail) begin
			ptr_q <= len_q - LEN_W'(1);
		end else if (cmd.ptr_first) begin
			ptr_q <= first_q;
		end
		if (cmd.first_set) begin
			first_q <= ptr_q;
		end
		if (cmd.stop_set) begin
			stop_q <= ptr_q + LEN_W'(1);
		end
	end

	// Genome position of the current base and its offset into the window.
	always_ff @(posedge clk) begin
		if (cmd.pos_init) begin
			pos_q <= {1'b0, hdr_pos_q} + 33'(ptr_q);
		end else if (cmd.step_inc) begin
			pos_q <= pos_q + 33'd1;
		end
		if (cmd.off_init) begin
			off_q <= {1'b0, pos_q} - {2'b00, win_beg_q};
		end else if (cmd.step_inc) begin
			off_q <= off_q + 34'd1;
		end
	end

	// Readout position and category.
	always_ff @(posedge clk) begin
		if (cmd.ro_load) begin
			ro_off_q <= {1'b0, read_pos} - {1'b0, win_beg_q};
			ro_cat_q <= category;
		end
	end

	// Clearing sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_rst) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + WIN_W'(1);
		end
	end

	// Status toward the controller.
	assign cur_q        = buf_rd_q[5:0];
	assign sts.clr_last = &clr_q;
	assign sts.trim     = (cur_q == 6'd0) || (cur_q == filt_q_q);
	assign sts.ptr_last = (ptr_q + LEN_W'(1)) == len_q;
	assign sts.acc_end  = (ptr_q == stop_q);
	assign sts.beyond   = pos_q > {1'b0, win_end_q};
	assign sts.in_win   = !off_q[33] && (off_q[32:0] < 33'(bpa_pkg::WINDOW));
	assign sts.q_ok     = (cur_q >= min_q_q) && (cur_q != filt_q_q);
	assign ro_in        = !ro_off_q[32] && (ro_off_q[31:0] < 32'(bpa_pkg::WINDOW));

	// Saturating row update for the current base.
	assign cur_cat   = bpa_pkg::category_of(hdr_strand_q, buf_rd_q[7:6]);
	assign cnt_old   = hdr_ori_q ? tab_rd_q.cnt_rev[cur_cat] : tab_rd_q.cnt_fwd[cur_cat];
	assign depth_inc = {1'b0, tab_rd_q.depth} + 17'd1;
	assign cnt_inc   = {1'b0, cnt_old} + 17'd1;
	assign qsum_inc  = {1'b0, tab_rd_q.qsum[cur_cat]} + 25'(cur_q);
	assign mapq_inc  = {1'b0, tab_rd_q.mapq_sum} + 33'(msq_q);

	always_comb begin
		row_new       = tab_rd_q;
		row_new.depth = depth_inc[16] ? 16'hFFFF : depth_inc[15:0];
		if (hdr_ori_q) begin
			row_new.cnt_rev[cur_cat] = cnt_inc[16] ? 16'hFFFF : cnt_inc[15:0];
		end else begin
			row_new.cnt_fwd[cur_cat] = cnt_inc[16] ? 16'hFFFF : cnt_inc[15:0];
		end
		row_new.qsum[cur_cat] = qsum_inc[24] ? 24'hFFFFFF : qsum_inc[23:0];
		row_new.mapq_sum      = mapq_inc[32] ? 32'hFFFFFFFF : mapq_inc[31:0];
	end

	// Pileup table memory: one write and one registered read per cycle.
	assign tab_rd_addr = cmd.tab_rd_ro ? ro_off_q[WIN_W-1:0] : off_q[WIN_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			tab_mem[clr_q] <= '0;
		end else if (cmd.tab_wr) begin
			tab_mem[off_q[WIN_W-1:0]] <= row_new;
		end
		if (cmd.tab_rd) begin
			tab_rd_q <= tab_mem[tab_rd_addr];
		end
	end

	// Result register; a position outside the table reads as zero.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (ro_in) begin
				depth                <= tab_rd_q.depth;
				category_quality_sum <= tab_rd_q.qsum[ro_cat_q];
				count_forward        <= tab_rd_q.cnt_fwd[ro_cat_q];
				count_reverse        <= tab_rd_q.cnt_rev[ro_cat_q];
				mapq_square_sum      <= tab_rd_q.mapq_sum;
			end else begin
				depth                <= '0;
				category_quality_sum <= '0;
				count_forward        <= '0;
				count_reverse        <= '0;
				mapq_square_sum      <= '0;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/bisulfite_pileup_accumulator_core.sv */
// Sequencing: a readout item reads its table row and then loads the result register once
// it is free; begin and non-last base items leave the block ready for the next item, and
// a clear item sweeps the whole table. A last base costs a buffer read and check per trimmed
// or skipped base, and per base added to the table a buffer read, table read and table write.
// Reset: asynchronous, active low; after reset a sweep zeroes the table and
// no item is accepted meanwhile (configuration writes are taken).
// ----------------------------------------------------------------------------
// Bisulfite pileup accumulator core
// Per-position base pileup over a genome window with trimming and readout.
// ----------------------------------------------------------------------------
`default_nettype none

module bisulfite_pileup_accumulator_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// read_pos[31:0], strand[33:32], orientation[34], mapq[42:35],
	// base_code[44:43], quality[50:45], category[53:51], zero pad[55:54]
	input  wire logic [55:0]  s_tdata,
	// kind[1:0]
	input  wire logic [1:0]   s_tuser,
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// depth[15:0], category_quality_sum[39:16], count_forward[55:40],
	// count_reverse[71:56], mapq_square_sum[103:72]
	output logic [103:0]      m_tdata
);

	bpa_pkg::cmd_t cmd;
	bpa_pkg::sts_t sts;

	// Sequencer.
	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage and arithmetic.
	bpa_datapath u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_wdata            (cfg_wdata),
		.read_pos             (s_tdata[31:0]),
		.strand               (s_tdata[33:32]),
		.orientation          (s_tdata[34]),
		.mapq                 (s_tdata[42:35]),
		.base_code            (s_tdata[44:43]),
		.quality              (s_tdata[50:45]),
		.category             (s_tdata[53:51]),
		.cmd                  (cmd),
		.sts                  (sts),
		.depth                (m_tdata[15:0]),
		.category_quality_sum (m_tdata[39:16]),
		.count_forward        (m_tdata[55:40]),
		.count_reverse        (m_tdata[71:56]),
		.mapq_square_sum      (m_tdata[103:72])
	);

	// A base is only buffered on an accepted item.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.buf_append |-> (s_tvalid && s_tready))
		else $error("base buffered without an accepted item");

	// A result is never loaded over one still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// Clearing and accumulation never share the table write port.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.tab_wr}))
		else $error("table write conflict");

	// Each accumulation write follows its own table read.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tab_wr |-> $past(cmd.tab_rd && !cmd.tab_rd_ro))
		else $error("table write without read");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Pileup accumulator testbench
// Sends reads, clears and readouts on the input stream and predicts each
// readout from a behavioral copy of the table or from a directed result.
// It runs through several window and quality settings. Both stream sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bpa_pkg::kind_t;
	import bpa_pkg::KIND_CLEAR;
	import bpa_pkg::KIND_BEGIN;
	import bpa_pkg::KIND_BASE;
	import bpa_pkg::KIND_READOUT;
	import bpa_pkg::CFG_MIN_Q;
	import bpa_pkg::CFG_FILT_Q;
	import bpa_pkg::CFG_WIN_BEG;
	import bpa_pkg::CFG_WIN_END;

	localparam int SPAN      = 1024;
	localparam int BUF_DEPTH = 512;
	localparam int STALL_LIM = 20000;
	localparam int SETTLE    = 3000;

	// One input item with its fields unpacked.
	typedef struct {
		kind_t       kind;
		logic [31:0] pos;
		logic [1:0]  strand;
		logic        ori;
		logic [7:0]  mapq;
		logic [1:0]  base;
		logic [5:0]  qual;
		logic        last;
		logic [2:0]  cat;
	} item_t;

	// One table entry as a readout returns it.
	typedef struct packed {
		logic [31:0] msum;
		logic [15:0] crev;
		logic [15:0] cfwd;
		logic [23:0] qsum;
		logic [15:0] depth;
	} entry_t;

	// A directed row: the item and, where known outright, its result.
	typedef struct {
		item_t  it;
		bit     typed;
		entry_t want;
	} dir_row_t;

	// Zero-based category per strand row and base.
	localparam logic [2:0] CAT_MAP [3][4] = '{
		'{3'd0, 3'd1, 3'd2, 3'd3},
		'{3'd0, 3'd5, 3'd2, 3'd7},
		'{3'd4, 3'd1, 3'd6, 3'd3}
	};

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [55:0]  s_tdata;
	logic [1:0]   s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;

	bisulfite_pileup_accumulator_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Predicted configuration and read state.
	logic [5:0]  min_q;
	logic [5:0]  filt_q;
	logic [31:0] win_beg;
	logic [31:0] win_end;
	logic [7:0]  read_buf [BUF_DEPTH];
	int          read_len;
	logic [31:0] hdr_pos;
	logic [1:0]  hdr_strand;
	logic        hdr_ori;
	logic [7:0]  hdr_mapq;

	// Predicted pileup table.
	logic [15:0] depth_tab [SPAN];
	logic [15:0] count_tab [2][SPAN][8];
	logic [23:0] qsum_tab [SPAN][8];
	logic [31:0] msum_tab [SPAN];

	entry_t   pending_readouts [$];
	dir_row_t dir_rows [$];

	int  n_items;
	int  n_checked;
	int  n_reads;
	int  n_errors;
	int  n_mismatch;
	int  idle_cycles;
	bit  quiet;
	bit  hold_go;
	bit  hold_seen;
	int  stall_cnt;
	logic [31:0] recent_pos;

	// Clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_trim(input logic [5:0] q);
		return q == 6'd0 || q == filt_q;
	endfunction

	function automatic void clear_pileup();
		foreach (depth_tab[i]) begin
			depth_tab[i] = '0;
			msum_tab[i] = '0;
			for (int c = 0; c < 8; c++) begin
				count_tab[0][i][c] = '0;
				count_tab[1][i][c] = '0;
				qsum_tab[i][c] = '0;
			end
		end
	endfunction

	// Trim the buffered read and add its kept bases to the table.
	function automatic void pile_read();
		int first;
		int stop;
		int idx;
		logic [63:0] p;
		logic [5:0] q;
		logic [2:0] c;
		logic [1:0] srow;
		logic [24:0] qs;
		logic [31:0] msq;
		first = 0;
		stop = read_len;
		srow = (hdr_strand == 2'd3) ? 2'd0 : hdr_strand;
		msq = hdr_mapq * hdr_mapq;
		while (first < read_len && is_trim(read_buf[first][5:0]))
			first++;
		if (first >= read_len)
			return;
		while (stop > first && is_trim(read_buf[stop-1][5:0]))
			stop--;
		for (int j = first; j < stop; j++) begin
			p = {32'd0, hdr_pos} + j;
			q = read_buf[j][5:0];
			if (p > {32'd0, win_end})
				break;
			if (p < {32'd0, win_beg} || p - {32'd0, win_beg} >= SPAN)
				continue;
			if (q < min_q || q == filt_q)
				continue;
			idx = int'(p - {32'd0, win_beg});
			c = CAT_MAP[srow][read_buf[j][7:6]];
			if (depth_tab[idx] != 16'hFFFF)
				depth_tab[idx]++;
			if (count_tab[hdr_ori][idx][c] != 16'hFFFF)
				count_tab[hdr_ori][idx][c]++;
			qs = {1'b0, qsum_tab[idx][c]} + q;
			qsum_tab[idx][c] = qs[24] ? 24'hFFFFFF : qs[23:0];
			msum_tab[idx] = (msum_tab[idx] > 32'hFFFFFFFF - msq) ? 32'hFFFFFFFF
				: msum_tab[idx] + msq;
		end
	endfunction

	// Advance the predicted state by one accepted item.
	function automatic void predict(input item_t it, input bit typed, input entry_t want);
		entry_t e;
		int idx;
		case (it.kind)
			KIND_CLEAR: clear_pileup();
			KIND_BEGIN: begin
				hdr_pos = it.pos;
				hdr_strand = it.strand;
				hdr_ori = it.ori;
				hdr_mapq = it.mapq;
				read_len = 0;
			end
			KIND_BASE: begin
				if (read_len < BUF_DEPTH) begin
					read_buf[read_len] = {it.base, it.qual};
					read_len++;
				end
				if (it.last) begin
					pile_read();
					read_len = 0;
					n_reads++;
				end
			end
			default: begin
				e = '0;
				if (it.pos >= win_beg && it.pos - win_beg < SPAN) begin
					idx = int'(it.pos - win_beg);
					e.depth = depth_tab[idx];
					e.qsum = qsum_tab[idx][it.cat];
					e.cfwd = count_tab[0][idx][it.cat];
					e.crev = count_tab[1][idx][it.cat];
					e.msum = msum_tab[idx];
				end
				pending_readouts.push_back(typed ? want : e);
			end
		endcase
	endfunction

	// Offer one item, idling first now and then, and wait until it is taken.
	task automatic send(input item_t it, input bit typed = 0, input entry_t want = '0);
		int gap;
		gap = (!quiet && $urandom_range(0, 99) < 6) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.kind;
		s_tlast <= it.last;
		s_tdata <= {2'b00, it.cat, it.qual, it.base, it.mapq, it.ori, it.strand, it.pos};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict(it, typed, want);
		n_items++;
		quiet <= (n_items >= 700 && n_items < 1000);
	endtask

	function automatic item_t mk(input kind_t k, input logic [31:0] pos = '0,
		input logic [1:0] strand = '0, input logic ori = 0, input logic [7:0] mapq = '0,
		input logic [1:0] base = '0, input logic [5:0] qual = '0, input logic last = 0,
		input logic [2:0] cat = '0);
		item_t it;
		it.kind = k;
		it.pos = pos;
		it.strand = strand;
		it.ori = ori;
		it.mapq = mapq;
		it.base = base;
		it.qual = qual;
		it.last = last;
		it.cat = cat;
		return it;
	endfunction

	function automatic void add_row(input item_t it, input bit typed = 0);
		dir_row_t r;
		r.it = it;
		r.typed = typed;
		r.want = '0;
		dir_rows.push_back(r);
	endfunction

	// Stop offering, wait out every expected readout, then let trailing work finish.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_readouts.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all four registers on consecutive edges.
	task automatic set_regs(input logic [5:0] mq, input logic [5:0] fq,
		input logic [31:0] wb, input logic [31:0] we);
		logic [1:0]  ids [4];
		logic [31:0] vals [4];
		ids = '{CFG_MIN_Q, CFG_FILT_Q, CFG_WIN_BEG, CFG_WIN_END};
		vals = '{{26'd0, mq}, {26'd0, fq}, wb, we};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= ids[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		min_q = mq;
		filt_q = fq;
		win_beg = wb;
		win_end = we;
	endtask

	// One read with random content, sometimes broken off before its last base.
	task automatic send_read();
		int len;
		int r;
		logic [5:0] q;
		bit broken;
		len = ($urandom_range(0, 59) == 0) ? $urandom_range(500, 530) : $urandom_range(1, 30);
		broken = ($urandom_range(0, 19) == 0);
		recent_pos = win_beg + $urandom_range(0, 1100) - 32'd40;
		send(mk(KIND_BEGIN, recent_pos, $urandom_range(0, 3), $urandom_range(0, 1),
			$urandom_range(0, 255)));
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 9);
			q = (r == 0) ? 6'd0 : (r == 1) ? filt_q : 6'($urandom_range(0, 63));
			send(mk(KIND_BASE, $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom_range(0, 3), q, (i == len - 1) && !broken, $urandom()));
		end
	endtask

	// Mostly well-formed reads and readouts of their positions, with some noise.
	task automatic run_random(input int count);
		int stop_at;
		int r;
		logic [31:0] p;
		stop_at = n_items + count;
		while (n_items < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				send_read();
			end else if (r < 85) begin
				p = ($urandom_range(0, 1) == 1) ? recent_pos + $urandom_range(0, 40)
					: win_beg + $urandom_range(0, SPAN + 20) - 32'd10;
				send(mk(KIND_READOUT, p, $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom_range(0, 7)));
			end else if (r < 87) begin
				send(mk(KIND_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom(), $urandom()));
			end else if (r < 93) begin
				send(mk(KIND_BASE, $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom(), $urandom()));
			end else if (r < 96) begin
				send(mk(KIND_BEGIN, $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom(), $urandom()));
			end else begin
				send(mk(KIND_READOUT, $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom(), $urandom()));
			end
		end
	endtask

	// Receiver: random stalls, one long hold-off, and a stretch with none.
	always @(posedge clk) begin
		if (hold_go && !hold_seen) begin
			hold_seen <= 1'b1;
			stall_cnt <= 400;
			m_tready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(0, 99) >= 6);
		end
	end

	// Compare each readout with the oldest prediction.
	always @(posedge clk) begin
		entry_t got;
		entry_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_readouts.size() == 0) begin
				n_errors++;
				$display("readout with no prediction waiting: %h", m_tdata);
			end else begin
				want = pending_readouts.pop_front();
				n_checked++;
				if (got !== want) begin
					n_errors++;
					n_mismatch++;
					if (n_mismatch <= 10)
						$display(
							"readout %0d: want depth %0d qsum %0d fwd %0d rev %0d msq %0d, got %0d %0d %0d %0d %0d",
							n_checked, want.depth, want.qsum, want.cfwd, want.crev,
							want.msum, got.depth, got.qsum, got.cfwd, got.crev, got.msum);
				end
			end
		end
	end

	// Watchdog on cycles in which neither side moves an item.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIM) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_CLEAR;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		quiet = 1'b0;
		hold_go = 1'b0;
		hold_seen = 1'b0;
		stall_cnt = 0;
		idle_cycles = 0;
		n_items = 0;
		n_checked = 0;
		n_reads = 0;
		n_errors = 0;
		n_mismatch = 0;
		recent_pos = '0;
		read_len = 0;
		hdr_pos = '0;
		hdr_strand = '0;
		hdr_ori = 1'b0;
		hdr_mapq = '0;
		clear_pileup();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		set_regs(6'd0, 6'd63, 32'd0, 32'd1023);

		// Directed rows: empty table, trimming, strands, extremes, clear.
		add_row(mk(KIND_READOUT, 32'd0, .cat(3'd0)), 1);
		add_row(mk(KIND_BEGIN, 32'd10, 2'd0, 1'b0, 8'd255));
		add_row(mk(KIND_BASE, .base(2'd3), .qual(6'd0)));
		add_row(mk(KIND_BASE, .base(2'd1), .qual(6'd63)));
		add_row(mk(KIND_BASE, .base(2'd0), .qual(6'd40)));
		add_row(mk(KIND_BASE, .base(2'd1), .qual(6'd63)));
		add_row(mk(KIND_BASE, .base(2'd2), .qual(6'd1)));
		add_row(mk(KIND_BASE, .base(2'd3), .qual(6'd0), .last(1'b1)));
		add_row(mk(KIND_READOUT, 32'd12, .cat(3'd0)));
		add_row(mk(KIND_BEGIN, 32'd1020, 2'd3, 1'b1, 8'd0));
		add_row(mk(KIND_BASE, .base(2'd1), .qual(6'd62)));
		add_row(mk(KIND_BASE, .base(2'd3), .qual(6'd30)));
		add_row(mk(KIND_BASE, .base(2'd0), .qual(6'd20)));
		add_row(mk(KIND_BASE, .base(2'd2), .qual(6'd20), .last(1'b1)));
		add_row(mk(KIND_BASE, .base(2'd2), .qual(6'd33), .last(1'b1)));
		add_row(mk(KIND_READOUT, 32'd1021, .cat(3'd3)));
		add_row(mk(KIND_BEGIN, 32'hFFFFFFFF, 2'd2, 1'b1, 8'd200));
		add_row(mk(KIND_BASE, .base(2'd1), .qual(6'd50), .last(1'b1)));
		add_row(mk(KIND_READOUT, 32'hFFFFFFFF, .cat(3'd7)), 1);
		add_row(mk(KIND_BEGIN, 32'd0, 2'd1, 1'b0, 8'd128));
		add_row(mk(KIND_BASE, .base(2'd3), .qual(6'd0), .last(1'b1)));
		add_row(mk(KIND_READOUT, 32'd1023, .cat(3'd7)));
		add_row(mk(KIND_CLEAR));
		add_row(mk(KIND_READOUT, 32'd12, .cat(3'd0)), 1);
		foreach (dir_rows[i])
			send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
		run_random(400);
		drain();

		// Narrow window, low filter marker; the receiver holds off meanwhile.
		set_regs(6'd20, 6'd2, 32'd100, 32'd600);
		run_random(60);
		hold_go <= 1'b1;
		for (int i = 0; i < 40; i++)
			send(mk(KIND_READOUT, win_beg + $urandom_range(0, 600), .cat($urandom_range(0, 7))));
		run_random(300);
		drain();

		// Window at the top of the position range, strictest quality.
		set_regs(6'd63, 6'd0, 32'hFFFFFC00, 32'hFFFFFFFF);
		run_random(350);
		drain();

		set_regs(6'd5, 6'd40, 32'h00010000, 32'h000103FF);
		run_random(350);
		drain();

		// Window ending at its first position.
		set_regs(6'd0, 6'd63, 32'd0, 32'd0);
		run_random(280);
		drain();

		$display("Sent %0d items (%0d reads closed) over five register settings.",
			n_items, n_reads);
		$display("Checked %0d readouts, %0d errors.", n_checked, n_errors);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
hdl/bpa_pkg.sv
hdl/bpa_ctrl.sv
hdl/bpa_datapath.sv
hdl/bisulfite_pileup_accumulator_core.sv
tb/tb_top.sv
